// ----- rtl/sukt_pkg.sv -----
// Package for the sorted unique key table: request and result types,
// operation and status codes, sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sukt_pkg;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_SEARCH   = 3'd2,
		OP_DUMP_ASC = 3'd3,
		OP_DUMP_DSC = 3'd4
	} op_code_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_code_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] flight_key;
		logic [11:0] depart_time;
		logic [9:0]  seats_total;
		logic [9:0]  seats_taken;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] entry_key;
		logic [11:0] entry_time;
		logic [9:0]  entry_seats_total;
		logic [9:0]  entry_seats_taken;
		logic [5:0]  entries_held;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [11:0] tim;
		logic [9:0]  cap;
		logic [9:0]  occ;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_FIND_WAIT,
		S_DECIDE,
		S_POS,
		S_POS_WAIT,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_DUMP,
		S_DUMP_WAIT,
		S_OUT
	} seq_state_t;

endpackage
`default_nettype wire

// ----- rtl/sukt_mem.sv -----
// Entry memory: one write port, one registered read port.
// Depends on sukt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sukt_mem
	import sukt_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);
	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/sorted_unique_key_table.sv -----
// Top level of the sorted unique key table: sequencer around one entry memory.
// Depends on sukt_pkg and sukt_mem.
//
// channel | dir | payload | handshake
// req     | in  | req_t   | req_valid / req_stall
// rsp     | out | rsp_t   | rsp_valid / rsp_stall
//
// One request at a time. Each memory step is a read, then a compare or write.
// Search/delete/insert: a key scan over the filled entries, then for an insert a time
// scan and a shift up, or for a delete a shift down.
// Dump: each entry passes S_DUMP, S_DUMP_WAIT and S_OUT. Reset empties the table at once.
// rsp_stall holds the result register and, in S_OUT, the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sorted_unique_key_table
	import sukt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int KEY_BYTES = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [63:0] KMASK = (KEY_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	seq_state_t state_q, state_d;
	req_t       req_q;
	logic [CW-1:0] fill_q, idx_q, pos_q, n_emit_q;
	logic        found_q;
	entry_t      hold_q;
	status_code_t status_q;
	logic        phase_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	entry_t      wdata, rdata;
	logic [CW-1:0] fill_next;
	logic        key_hit, out_ready, dump_more;

	sukt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign key_hit = (rdata.key == (req_q.flight_key & KMASK));
	assign out_ready = !rsp_valid || !rsp_stall;
	assign dump_more = (req_q.op == OP_DUMP_ASC || req_q.op == OP_DUMP_DSC) &&
		fill_q != '0 && (n_emit_q + CW'(1) < fill_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) begin
				if (req.op == OP_DUMP_ASC || req.op == OP_DUMP_DSC)
					state_d = (fill_q == '0) ? S_OUT : S_DUMP;
				else if (req.op > OP_DUMP_DSC) state_d = S_OUT;
				else state_d = S_FIND;
			end
			S_FIND:      state_d = (idx_q < fill_q) ? S_FIND_WAIT : S_DECIDE;
			S_FIND_WAIT: state_d = key_hit ? S_DECIDE : S_FIND;
			S_DECIDE: begin
				state_d = S_OUT;
				if (req_q.op == OP_INSERT && !found_q && fill_q < CW'(TABLE_DEPTH))
					state_d = S_POS;
				else if (req_q.op == OP_DELETE && found_q)
					state_d = S_SHIFT_DN;
			end
			S_POS:       state_d = (idx_q < fill_q) ? S_POS_WAIT : S_SHIFT_UP;
			S_POS_WAIT:  state_d = (rdata.tim > req_q.depart_time) ? S_SHIFT_UP : S_POS;
			S_SHIFT_UP:  if (phase_q && idx_q == pos_q) state_d = S_OUT;
			S_SHIFT_DN:  if (idx_q + CW'(1) >= fill_q) state_d = S_OUT;
			S_DUMP:      state_d = S_DUMP_WAIT;
			S_DUMP_WAIT: state_d = S_OUT;
			S_OUT:       if (out_ready) state_d = dump_more ? S_DUMP : S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// memory address, write enable and write data; shifts alternate read/write via idx_q and a phase bit
	always_comb begin
		raddr = idx_q[AW-1:0];
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		if (state_q == S_SHIFT_UP) begin
			// idx_q is destination; read idx-1 on phase 0, write on phase 1
			raddr = AW'(idx_q - CW'(1));
			if (phase_q) begin
				we = 1'b1;
				if (idx_q == pos_q) begin
					wdata.key = req_q.flight_key & KMASK;
					wdata.tim = req_q.depart_time;
					wdata.cap = req_q.seats_total;
					wdata.occ = req_q.seats_taken;
				end
			end
		end else if (state_q == S_SHIFT_DN) begin
			raddr = AW'(idx_q + CW'(1));
			we = phase_q;
		end
	end

	assign fill_next = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			rsp_valid <= 1'b0;
			idx_q <= '0;
			phase_q <= 1'b0;
			found_q <= 1'b0;
			req_q <= '0;
			pos_q <= '0;
			n_emit_q <= '0;
			hold_q <= '0;
			status_q <= ST_OK;
			rsp <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_ready) rsp_valid <= 1'b1;
			else if (!rsp_stall) rsp_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_valid) begin
					req_q <= req;
					idx_q <= (req.op == OP_DUMP_DSC && fill_q != '0) ?
						fill_q - CW'(1) : '0;
					found_q <= 1'b0;
					if (req.op == OP_DUMP_ASC || req.op == OP_DUMP_DSC) begin
						n_emit_q <= '0;
						if (fill_q == '0) begin
							status_q <= ST_EMPTY;
							hold_q <= '0;
						end
					end else if (req.op > OP_DUMP_DSC) begin
						status_q <= ST_OK;
						hold_q <= '0;
					end
				end
				S_FIND_WAIT: begin
					if (key_hit) begin
						found_q <= 1'b1;
						hold_q <= rdata;
						pos_q <= idx_q;
					end else idx_q <= idx_q + CW'(1);
				end
				S_FIND: ;
				S_DECIDE: begin
					hold_q <= found_q ? hold_q : '0;
					unique case (req_q.op)
						OP_INSERT: begin
							if (found_q) status_q <= ST_DUP;
							else if (fill_q >= CW'(TABLE_DEPTH)) status_q <= ST_FULL;
							else begin
								status_q <= ST_OK;
								idx_q <= '0;
							end
						end
						OP_DELETE: begin
							if (!found_q) status_q <= ST_NOTFOUND;
							else begin
								status_q <= ST_OK;
								idx_q <= pos_q;
								phase_q <= 1'b0;
							end
						end
						default: status_q <= found_q ? ST_OK : ST_NOTFOUND;
					endcase
				end
				S_POS_WAIT: begin
					if (rdata.tim > req_q.depart_time) begin
						pos_q <= idx_q;
						idx_q <= fill_q;
						phase_q <= 1'b0;
					end else idx_q <= idx_q + CW'(1);
				end
				S_POS: if (!(idx_q < fill_q)) begin
					pos_q <= idx_q;
					phase_q <= 1'b0;
				end
				S_SHIFT_UP: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						if (idx_q == pos_q) begin
							hold_q <= wdata;
							fill_q <= fill_q + CW'(1);
						end else idx_q <= idx_q - CW'(1);
					end
				end
				S_SHIFT_DN: begin
					phase_q <= ~phase_q;
					if (idx_q + CW'(1) >= fill_q) begin
						fill_q <= fill_q - CW'(1);
					end else if (phase_q) idx_q <= idx_q + CW'(1);
				end
				S_DUMP: ;
				S_DUMP_WAIT: begin
					hold_q <= rdata;
					status_q <= ST_OK;
				end
				S_OUT: if (out_ready) begin
					rsp.status <= status_q;
					rsp.entry_key <= hold_q.key;
					rsp.entry_time <= hold_q.tim;
					rsp.entry_seats_total <= hold_q.cap;
					rsp.entry_seats_taken <= hold_q.occ;
					rsp.entries_held <= 6'(fill_next);
					rsp.last <= !dump_more;
					if (dump_more) begin
						n_emit_q <= n_emit_q + CW'(1);
						idx_q <= (req_q.op == OP_DUMP_ASC) ? idx_q + CW'(1)
							: idx_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sukt_checker.sv -----
// Port checker for the sorted unique key table, bound to the top level.
// Depends on sukt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sukt_checker
	import sukt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall) else $error("accept mid dump");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall) else $error("no busy after accept");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_EMPTY) else $error("status");
endmodule
bind sorted_unique_key_table sukt_checker u_chk (.*);
`default_nettype wire
